>>> sv/particle_frame_rotation_core_macros.svh
// Assertion macros for the particle frame rotation core.
// Both macros sample on clock and are disabled while reset is high.
`ifndef PARTICLE_FRAME_ROTATION_CORE_MACROS_SVH
`define PARTICLE_FRAME_ROTATION_CORE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define PFR_ASSERT_HOLDS(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pfr assertion failed");

// Next-cycle implication.
`define PFR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pfr assertion failed");

`else

`define PFR_ASSERT_HOLDS(label, ante, cons)
`define PFR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> sv/pfr_pkg.sv
package pfr_pkg;

   localparam int FRAC_SHIFT = 30;
   localparam int ANGLE_W    = 32;
   localparam int LIMIT_W    = 64;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COS_ANGLE       = 3'd0,
      CSR_SIN_ANGLE       = 3'd1,
      CSR_CORIOLIS_GAIN   = 3'd2,
      CSR_RADIUS_LIMIT_SQ = 3'd3,
      CSR_LIMIT_ENABLE    = 3'd4
   } csr_idx_type;

   // 1.0 in Q2.30
   localparam logic signed [ANGLE_W-1:0] COS_RESET = 32'sh4000_0000;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] cos_angle;
      logic signed [ANGLE_W-1:0] sin_angle;
      logic signed [ANGLE_W-1:0] coriolis_gain;
      logic [LIMIT_W-1:0]        radius_limit_sq;
      logic                      limit_enable;
   } cfg_type;

endpackage

>>> sv/pfr_diff.sv
module pfr_diff #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [COORD_WIDTH-1:0] pos_x,
   input  logic signed [COORD_WIDTH-1:0] pos_y,
   input  logic signed [COORD_WIDTH-1:0] pos_z,
   input  logic signed [COORD_WIDTH-1:0] vel_x,
   input  logic signed [COORD_WIDTH-1:0] vel_y,
   input  logic signed [COORD_WIDTH-1:0] ref_pos_x,
   input  logic signed [COORD_WIDTH-1:0] ref_pos_y,
   input  logic signed [COORD_WIDTH-1:0] ref_pos_z,
   input  logic signed [COORD_WIDTH-1:0] ref_vel_x,
   input  logic signed [COORD_WIDTH-1:0] ref_vel_y,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [COORD_WIDTH:0]   dx,
   output logic signed [COORD_WIDTH:0]   dy,
   output logic signed [COORD_WIDTH:0]   dz,
   output logic signed [COORD_WIDTH:0]   vx,
   output logic signed [COORD_WIDTH:0]   vy
);

   localparam int DW = COORD_WIDTH + 1;

   logic                 valid_ff;
   logic signed [DW-1:0] dx_in, dy_in, dz_in, vx_in, vy_in;
   logic signed [DW-1:0] dx_ff, dy_ff, dz_ff, vx_ff, vy_ff;

   assign in_ready = ~valid_ff | out_ready;

   // exact differences, one bit wider than a coordinate
   always_comb begin
      dx_in = DW'(pos_x) - DW'(ref_pos_x);
      dy_in = DW'(pos_y) - DW'(ref_pos_y);
      dz_in = DW'(pos_z) - DW'(ref_pos_z);
      vx_in = DW'(vel_x) - DW'(ref_vel_x);
      vy_in = DW'(vel_y) - DW'(ref_vel_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         dz_ff <= dz_in;
         vx_ff <= vx_in;
         vy_ff <= vy_in;
      end
   end

   assign out_valid = valid_ff;
   assign dx        = dx_ff;
   assign dy        = dy_ff;
   assign dz        = dz_ff;
   assign vx        = vx_ff;
   assign vy        = vy_ff;

endmodule

>>> sv/pfr_rotate.sv
module pfr_rotate import pfr_pkg::*; #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  cfg_type                         cfg,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic signed [COORD_WIDTH:0]     dx,
   input  logic signed [COORD_WIDTH:0]     dy,
   input  logic signed [COORD_WIDTH:0]     dz,
   input  logic signed [COORD_WIDTH:0]     vx,
   input  logic signed [COORD_WIDTH:0]     vy,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic signed [COORD_WIDTH+3:0]   x1,
   output logic signed [COORD_WIDTH+3:0]   y1,
   output logic signed [COORD_WIDTH+3:0]   v1x,
   output logic signed [COORD_WIDTH+3:0]   v1y,
   output logic signed [COORD_WIDTH:0]     dx_out,
   output logic signed [COORD_WIDTH:0]     dy_out,
   output logic signed [COORD_WIDTH:0]     vx_out,
   output logic signed [COORD_WIDTH:0]     vy_out,
   output logic [LIMIT_W-1:0]              rsq_xy,
   output logic [LIMIT_W-1:0]              rsq_z
);

   localparam int DW  = COORD_WIDTH + 1;
   localparam int PW  = DW + ANGLE_W;
   localparam int SW  = PW + 1;
   localparam int RW  = COORD_WIDTH + 4;
   localparam int SQW = 2 * DW;
   localparam logic signed [SW-1:0] HALF = SW'(64'd1 << (FRAC_SHIFT - 1));

   function automatic logic signed [RW-1:0] round_back(input logic signed [SW-1:0] s);
      logic signed [SW-1:0] t;
      t = s + HALF;
      return t[FRAC_SHIFT+RW-1:FRAC_SHIFT];
   endfunction

   function automatic logic [LIMIT_W-1:0] sat_sq(input logic [SQW-1:0] s);
      logic [SQW+LIMIT_W-1:0] e;
      e = {{LIMIT_W{1'b0}}, s};
      return (|e[SQW+LIMIT_W-1:LIMIT_W]) ? {LIMIT_W{1'b1}} : e[LIMIT_W-1:0];
   endfunction

   function automatic logic [DW-1:0] magnitude(input logic signed [DW-1:0] d);
      return d[DW-1] ? (~d + 1'b1) : d;
   endfunction

   // ---- stage A: products and squares
   logic                 a_valid_ff;
   logic                 a_en;
   logic signed [PW-1:0] pxc_in, pys_in, pxs_in, pyc_in;
   logic signed [PW-1:0] qxc_in, qys_in, qxs_in, qyc_in;
   logic signed [PW-1:0] pxc_ff, pys_ff, pxs_ff, pyc_ff;
   logic signed [PW-1:0] qxc_ff, qys_ff, qxs_ff, qyc_ff;
   logic [DW-1:0]        mx, my, mz;
   logic [SQW-1:0]       sqx_in, sqy_in, sqz_in;
   logic [SQW-1:0]       sqx_ff, sqy_ff, sqz_ff;
   logic signed [DW-1:0] adx_ff, ady_ff, avx_ff, avy_ff;

   // ---- stage B: rounded rotation and partial squared radius
   logic                 b_valid_ff;
   logic                 b_en;
   logic signed [RW-1:0] x1_in, y1_in, v1x_in, v1y_in;
   logic signed [RW-1:0] x1_ff, y1_ff, v1x_ff, v1y_ff;
   logic [LIMIT_W:0]     sum_xy;
   logic [LIMIT_W-1:0]   rsq_xy_in, rsq_z_in;
   logic [LIMIT_W-1:0]   rsq_xy_ff, rsq_z_ff;
   logic signed [DW-1:0] bdx_ff, bdy_ff, bvx_ff, bvy_ff;

   assign b_en     = ~b_valid_ff | out_ready;
   assign a_en     = ~a_valid_ff | b_en;
   assign in_ready = a_en;

   always_comb begin
      pxc_in = PW'(dx) * PW'(cfg.cos_angle);
      pys_in = PW'(dy) * PW'(cfg.sin_angle);
      pxs_in = PW'(dx) * PW'(cfg.sin_angle);
      pyc_in = PW'(dy) * PW'(cfg.cos_angle);
      qxc_in = PW'(vx) * PW'(cfg.cos_angle);
      qys_in = PW'(vy) * PW'(cfg.sin_angle);
      qxs_in = PW'(vx) * PW'(cfg.sin_angle);
      qyc_in = PW'(vy) * PW'(cfg.cos_angle);
      mx     = magnitude(dx);
      my     = magnitude(dy);
      mz     = magnitude(dz);
      sqx_in = SQW'(mx) * SQW'(mx);
      sqy_in = SQW'(my) * SQW'(my);
      sqz_in = SQW'(mz) * SQW'(mz);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_en) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_en && in_valid) begin
         pxc_ff <= pxc_in;
         pys_ff <= pys_in;
         pxs_ff <= pxs_in;
         pyc_ff <= pyc_in;
         qxc_ff <= qxc_in;
         qys_ff <= qys_in;
         qxs_ff <= qxs_in;
         qyc_ff <= qyc_in;
         sqx_ff <= sqx_in;
         sqy_ff <= sqy_in;
         sqz_ff <= sqz_in;
         adx_ff <= dx;
         ady_ff <= dy;
         avx_ff <= vx;
         avy_ff <= vy;
      end
   end

   always_comb begin
      x1_in     = round_back(SW'(pxc_ff) - SW'(pys_ff));
      y1_in     = round_back(SW'(pxs_ff) + SW'(pyc_ff));
      v1x_in    = round_back(SW'(qxc_ff) - SW'(qys_ff));
      v1y_in    = round_back(SW'(qxs_ff) + SW'(qyc_ff));
      sum_xy    = {1'b0, sat_sq(sqx_ff)} + {1'b0, sat_sq(sqy_ff)};
      rsq_xy_in = sum_xy[LIMIT_W] ? {LIMIT_W{1'b1}} : sum_xy[LIMIT_W-1:0];
      rsq_z_in  = sat_sq(sqz_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_en && a_valid_ff) begin
         x1_ff     <= x1_in;
         y1_ff     <= y1_in;
         v1x_ff    <= v1x_in;
         v1y_ff    <= v1y_in;
         rsq_xy_ff <= rsq_xy_in;
         rsq_z_ff  <= rsq_z_in;
         bdx_ff    <= adx_ff;
         bdy_ff    <= ady_ff;
         bvx_ff    <= avx_ff;
         bvy_ff    <= avy_ff;
      end
   end

   assign out_valid = b_valid_ff;
   assign x1        = x1_ff;
   assign y1        = y1_ff;
   assign v1x       = v1x_ff;
   assign v1y       = v1y_ff;
   assign dx_out    = bdx_ff;
   assign dy_out    = bdy_ff;
   assign vx_out    = bvx_ff;
   assign vy_out    = bvy_ff;
   assign rsq_xy    = rsq_xy_ff;
   assign rsq_z     = rsq_z_ff;

endmodule

>>> sv/pfr_correct.sv
module pfr_correct import pfr_pkg::*; #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  cfg_type                         cfg,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic signed [COORD_WIDTH+3:0]   x1,
   input  logic signed [COORD_WIDTH+3:0]   y1,
   input  logic signed [COORD_WIDTH+3:0]   v1x,
   input  logic signed [COORD_WIDTH+3:0]   v1y,
   input  logic signed [COORD_WIDTH:0]     dx,
   input  logic signed [COORD_WIDTH:0]     dy,
   input  logic signed [COORD_WIDTH:0]     vx,
   input  logic signed [COORD_WIDTH:0]     vy,
   input  logic [LIMIT_W-1:0]              rsq_xy,
   input  logic [LIMIT_W-1:0]              rsq_z,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic                            applied,
   output logic signed [COORD_WIDTH-1:0]   dpos_x,
   output logic signed [COORD_WIDTH-1:0]   dpos_y,
   output logic signed [COORD_WIDTH-1:0]   dvel_x,
   output logic signed [COORD_WIDTH-1:0]   dvel_y
);

   localparam int RW  = COORD_WIDTH + 4;
   localparam int EW  = COORD_WIDTH + 5;
   localparam int CPW = RW + ANGLE_W;
   localparam int CRW = COORD_WIDTH + 6;
   localparam int XW  = COORD_WIDTH + 8;
   localparam logic signed [CPW-1:0] HALF   = CPW'(64'd1 << (FRAC_SHIFT - 1));
   localparam logic signed [XW-1:0]  SAT_HI = (XW'(1) <<< (COORD_WIDTH - 1)) - XW'(1);
   localparam logic signed [XW-1:0]  SAT_LO = -(XW'(1) <<< (COORD_WIDTH - 1));

   function automatic logic signed [CRW-1:0] round_back(input logic signed [CPW-1:0] p);
      logic signed [CPW-1:0] t;
      t = p + HALF;
      return t[FRAC_SHIFT+CRW-1:FRAC_SHIFT];
   endfunction

   function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
      input logic signed [XW-1:0] v
   );
      logic signed [XW-1:0] c;
      c = v;
      if (v > SAT_HI) c = SAT_HI;
      if (v < SAT_LO) c = SAT_LO;
      return c[COORD_WIDTH-1:0];
   endfunction

   // ---- stage A: Coriolis products, position and velocity deltas, radius test
   logic                  a_valid_ff;
   logic                  a_en;
   logic signed [EW-1:0]  dpx_in, dpy_in, pvx_in, pvy_in;
   logic signed [EW-1:0]  dpx_ff, dpy_ff, pvx_ff, pvy_ff;
   logic signed [CPW-1:0] cx_in, cy_in;
   logic signed [CPW-1:0] cx_ff, cy_ff;
   logic [LIMIT_W:0]      sum_r;
   logic [LIMIT_W-1:0]    rsq;
   logic                  inside_in;
   logic                  inside_ff;

   // ---- stage B: output register
   logic                          b_valid_ff;
   logic                          b_en;
   logic                          applied_ff;
   logic signed [COORD_WIDTH-1:0] dpos_x_in, dpos_y_in, dvel_x_in, dvel_y_in;
   logic signed [COORD_WIDTH-1:0] dpos_x_ff, dpos_y_ff, dvel_x_ff, dvel_y_ff;

   assign b_en     = ~b_valid_ff | out_ready;
   assign a_en     = ~a_valid_ff | b_en;
   assign in_ready = a_en;

   always_comb begin
      dpx_in    = EW'(x1) - EW'(dx);
      dpy_in    = EW'(y1) - EW'(dy);
      pvx_in    = EW'(v1x) - EW'(vx);
      pvy_in    = EW'(v1y) - EW'(vy);
      // x gets minus v1y*gain, y gets plus v1x*gain
      cx_in     = CPW'(v1y) * CPW'(cfg.coriolis_gain);
      cy_in     = CPW'(v1x) * CPW'(cfg.coriolis_gain);
      sum_r     = {1'b0, rsq_xy} + {1'b0, rsq_z};
      rsq       = sum_r[LIMIT_W] ? {LIMIT_W{1'b1}} : sum_r[LIMIT_W-1:0];
      inside_in = ~cfg.limit_enable | (rsq < cfg.radius_limit_sq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_en) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_en && in_valid) begin
         dpx_ff    <= dpx_in;
         dpy_ff    <= dpy_in;
         pvx_ff    <= pvx_in;
         pvy_ff    <= pvy_in;
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         inside_ff <= inside_in;
      end
   end

   // drop all deltas to zero outside the radius
   always_comb begin
      if (inside_ff) begin
         dpos_x_in = sat_coord(XW'(dpx_ff));
         dpos_y_in = sat_coord(XW'(dpy_ff));
         dvel_x_in = sat_coord(XW'(pvx_ff) - XW'(round_back(cx_ff)));
         dvel_y_in = sat_coord(XW'(pvy_ff) + XW'(round_back(cy_ff)));
      end else begin
         dpos_x_in = '0;
         dpos_y_in = '0;
         dvel_x_in = '0;
         dvel_y_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_en && a_valid_ff) begin
         applied_ff <= inside_ff;
         dpos_x_ff  <= dpos_x_in;
         dpos_y_ff  <= dpos_y_in;
         dvel_x_ff  <= dvel_x_in;
         dvel_y_ff  <= dvel_y_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign applied   = applied_ff;
   assign dpos_x    = dpos_x_ff;
   assign dpos_y    = dpos_y_ff;
   assign dvel_x    = dvel_x_ff;
   assign dvel_y    = dvel_y_ff;

endmodule

>>> sv/particle_frame_rotation_core.sv
// Rotating-frame correction for a stream of particles.
// req_* carries one particle per beat: position, velocity and the reference
// position and velocity, all signed Q.16 coordinates of COORD_WIDTH bits.
// rsp_* returns one beat per particle, in order: applied, and the x/y
// position and velocity deltas (saturated). No z deltas are returned,
// and req_vel_z and req_ref_vel_z do not affect any result.
// csr_* writes the angle cosine and sine, the Coriolis gain, the squared
// radius limit and the limit enable; write them only while the core is idle.
// Five register stages: subtract, multiply, round, Coriolis multiply,
// output register. One particle enters every cycle while rsp_ready is high.
// Each stage takes a new beat when it is empty or its successor moves, so
// bubbles close up and req_ready stays high while rsp_ready is high.
// When rsp_ready is low, the output beat holds and the stages behind it
// fill; req_ready drops once all five hold a particle.
// Reset empties the pipeline and loads cos = 1.0, everything else zero.
`include "particle_frame_rotation_core_macros.svh"

module particle_frame_rotation_core import pfr_pkg::*; #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [CSR_IDX_W-1:0]          csr_addr,
   input  logic [CSR_DATA_W-1:0]         csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_pos_x,
   input  logic signed [COORD_WIDTH-1:0] req_pos_y,
   input  logic signed [COORD_WIDTH-1:0] req_pos_z,
   input  logic signed [COORD_WIDTH-1:0] req_vel_x,
   input  logic signed [COORD_WIDTH-1:0] req_vel_y,
   input  logic signed [COORD_WIDTH-1:0] req_vel_z,
   input  logic signed [COORD_WIDTH-1:0] req_ref_pos_x,
   input  logic signed [COORD_WIDTH-1:0] req_ref_pos_y,
   input  logic signed [COORD_WIDTH-1:0] req_ref_pos_z,
   input  logic signed [COORD_WIDTH-1:0] req_ref_vel_x,
   input  logic signed [COORD_WIDTH-1:0] req_ref_vel_y,
   input  logic signed [COORD_WIDTH-1:0] req_ref_vel_z,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_applied,
   output logic signed [COORD_WIDTH-1:0] rsp_dpos_x,
   output logic signed [COORD_WIDTH-1:0] rsp_dpos_y,
   output logic signed [COORD_WIDTH-1:0] rsp_dvel_x,
   output logic signed [COORD_WIDTH-1:0] rsp_dvel_y
);

   localparam int DW = COORD_WIDTH + 1;
   localparam int RW = COORD_WIDTH + 4;

   cfg_type cfg_in, cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_addr)
            CSR_COS_ANGLE:       cfg_in.cos_angle       = csr_wdata[ANGLE_W-1:0];
            CSR_SIN_ANGLE:       cfg_in.sin_angle       = csr_wdata[ANGLE_W-1:0];
            CSR_CORIOLIS_GAIN:   cfg_in.coriolis_gain   = csr_wdata[ANGLE_W-1:0];
            CSR_RADIUS_LIMIT_SQ: cfg_in.radius_limit_sq = csr_wdata[LIMIT_W-1:0];
            CSR_LIMIT_ENABLE:    cfg_in.limit_enable    = csr_wdata[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cos_angle       <= COS_RESET;
         cfg_ff.sin_angle       <= '0;
         cfg_ff.coriolis_gain   <= '0;
         cfg_ff.radius_limit_sq <= '0;
         cfg_ff.limit_enable    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   logic                 diff_valid, diff_ready;
   logic signed [DW-1:0] diff_dx, diff_dy, diff_dz, diff_vx, diff_vy;

   logic                 rot_valid, rot_ready;
   logic signed [RW-1:0] rot_x1, rot_y1, rot_v1x, rot_v1y;
   logic signed [DW-1:0] rot_dx, rot_dy, rot_vx, rot_vy;
   logic [LIMIT_W-1:0]   rot_rsq_xy, rot_rsq_z;

   pfr_diff #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_diff (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .pos_x     (req_pos_x),
      .pos_y     (req_pos_y),
      .pos_z     (req_pos_z),
      .vel_x     (req_vel_x),
      .vel_y     (req_vel_y),
      .ref_pos_x (req_ref_pos_x),
      .ref_pos_y (req_ref_pos_y),
      .ref_pos_z (req_ref_pos_z),
      .ref_vel_x (req_ref_vel_x),
      .ref_vel_y (req_ref_vel_y),
      .out_valid (diff_valid),
      .out_ready (diff_ready),
      .dx        (diff_dx),
      .dy        (diff_dy),
      .dz        (diff_dz),
      .vx        (diff_vx),
      .vy        (diff_vy)
   );

   pfr_rotate #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_rotate (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (diff_valid),
      .in_ready  (diff_ready),
      .dx        (diff_dx),
      .dy        (diff_dy),
      .dz        (diff_dz),
      .vx        (diff_vx),
      .vy        (diff_vy),
      .out_valid (rot_valid),
      .out_ready (rot_ready),
      .x1        (rot_x1),
      .y1        (rot_y1),
      .v1x       (rot_v1x),
      .v1y       (rot_v1y),
      .dx_out    (rot_dx),
      .dy_out    (rot_dy),
      .vx_out    (rot_vx),
      .vy_out    (rot_vy),
      .rsq_xy    (rot_rsq_xy),
      .rsq_z     (rot_rsq_z)
   );

   pfr_correct #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_correct (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (rot_valid),
      .in_ready  (rot_ready),
      .x1        (rot_x1),
      .y1        (rot_y1),
      .v1x       (rot_v1x),
      .v1y       (rot_v1y),
      .dx        (rot_dx),
      .dy        (rot_dy),
      .vx        (rot_vx),
      .vy        (rot_vy),
      .rsq_xy    (rot_rsq_xy),
      .rsq_z     (rot_rsq_z),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .applied   (rsp_applied),
      .dpos_x    (rsp_dpos_x),
      .dpos_y    (rsp_dpos_y),
      .dvel_x    (rsp_dvel_x),
      .dvel_y    (rsp_dvel_y)
   );

   // a draining output lets every stage advance
   `PFR_ASSERT_HOLDS(a_ready_when_drained, rsp_ready, req_ready)
   // an accepted beat lands in the subtract stage
   `PFR_ASSERT_NEXT(a_accept_loads_diff, req_valid && req_ready, diff_valid)
   // particles outside the radius report zero deltas
   `PFR_ASSERT_HOLDS(a_outside_is_zero, rsp_valid && !rsp_applied, rsp_dpos_x == '0 && rsp_dpos_y == '0 && rsp_dvel_x == '0 && rsp_dvel_y == '0)

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import pfr_pkg::*;

   localparam int COORD_W = 32;
   localparam int QUIET_LIMIT = 4000;
   localparam int HOLD_CYCLES = 60;
   localparam int PHASE_ITEMS = 75;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_IDX = 3'd7;

   localparam logic signed [31:0] Q30_ONE     = COS_RESET;
   localparam logic signed [31:0] Q30_NEG_ONE = 32'shC000_0000;
   localparam logic signed [31:0] COS_45      = 32'sd759250125;
   localparam logic signed [31:0] GAIN_MAX    = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] GAIN_MIN    = 32'sh8000_0000;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
   // (10.0)^2 in Q32.32 plus one lsb
   localparam logic [LIMIT_W-1:0] RADIUS_EDGE = 64'h0000_0064_0000_0001;

   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x, pos_y, pos_z;
      logic signed [COORD_W-1:0] vel_x, vel_y, vel_z;
      logic signed [COORD_W-1:0] ref_pos_x, ref_pos_y, ref_pos_z;
      logic signed [COORD_W-1:0] ref_vel_x, ref_vel_y, ref_vel_z;
   } particle_beat;

   typedef struct packed {
      logic                      applied;
      logic signed [COORD_W-1:0] dpos_x, dpos_y, dvel_x, dvel_y;
   } frame_delta;

   class rotation_scoreboard;
      cfg_type    regs;
      frame_delta expected_q[$];
      int unsigned errors;

      function new();
         regs.cos_angle       = COS_RESET;
         regs.sin_angle       = '0;
         regs.coriolis_gain   = '0;
         regs.radius_limit_sq = '0;
         regs.limit_enable    = 1'b0;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_COS_ANGLE:       regs.cos_angle = data[ANGLE_W-1:0];
            CSR_SIN_ANGLE:       regs.sin_angle = data[ANGLE_W-1:0];
            CSR_CORIOLIS_GAIN:   regs.coriolis_gain = data[ANGLE_W-1:0];
            CSR_RADIUS_LIMIT_SQ: regs.radius_limit_sq = data[LIMIT_W-1:0];
            CSR_LIMIT_ENABLE:    regs.limit_enable = data[0];
            default: ;
         endcase
      endfunction

      // round half up, drop the Q2.30 fraction
      function logic signed [127:0] round_q30(logic signed [127:0] a);
         return (a + 128'sd536870912) >>> FRAC_SHIFT;
      endfunction

      function logic signed [COORD_W-1:0] sat_coord(logic signed [127:0] v);
         if (v > 128'sd2147483647) return COORD_MAX;
         if (v < -128'sd2147483648) return COORD_MIN;
         return v[COORD_W-1:0];
      endfunction

      function frame_delta rotate_particle(particle_beat p);
         logic signed [127:0] dx, dy, dz, vx, vy, c, s, g;
         logic signed [127:0] x1, y1, v1x, v1y, rsq_sum;
         logic [LIMIT_W-1:0]  rsq;
         frame_delta r;
         dx = $signed(p.pos_x) - $signed(p.ref_pos_x);
         dy = $signed(p.pos_y) - $signed(p.ref_pos_y);
         dz = $signed(p.pos_z) - $signed(p.ref_pos_z);
         vx = $signed(p.vel_x) - $signed(p.ref_vel_x);
         vy = $signed(p.vel_y) - $signed(p.ref_vel_y);
         rsq_sum = dx * dx + dy * dy + dz * dz;
         rsq = (rsq_sum[127:64] != 0) ? '1 : rsq_sum[63:0];
         r = '0;
         if (regs.limit_enable && !(rsq < regs.radius_limit_sq))
            return r;
         c = $signed(regs.cos_angle);
         s = $signed(regs.sin_angle);
         g = $signed(regs.coriolis_gain);
         x1  = round_q30(dx * c - dy * s);
         y1  = round_q30(dx * s + dy * c);
         v1x = round_q30(vx * c - vy * s);
         v1y = round_q30(vx * s + vy * c);
         r.applied = 1'b1;
         r.dpos_x = sat_coord(x1 - dx);
         r.dpos_y = sat_coord(y1 - dy);
         r.dvel_x = sat_coord((v1x - vx) - round_q30(v1y * g));
         r.dvel_y = sat_coord((v1y - vy) + round_q30(v1x * g));
         return r;
      endfunction

      function void note_particle(particle_beat p);
         expected_q.push_back(rotate_particle(p));
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void compare_field(string name, logic signed [31:0] want, logic signed [31:0] got);
         if (got !== want) begin
            errors++;
            $error("%s: expected %0d, got %0d", name, want, got);
         end
      endfunction

      function void check_result(frame_delta got);
         frame_delta want;
         if (expected_q.size() == 0) begin
            errors++;
            $error("rsp beat with no particle outstanding");
            return;
         end
         want = expected_q.pop_front();
         compare_field("applied", want.applied, got.applied);
         compare_field("dpos_x", want.dpos_x, got.dpos_x);
         compare_field("dpos_y", want.dpos_y, got.dpos_y);
         compare_field("dvel_x", want.dvel_x, got.dvel_x);
         compare_field("dvel_y", want.dvel_y, got.dvel_y);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   particle_beat req_beat = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_applied;
   logic signed [COORD_W-1:0] rsp_dpos_x, rsp_dpos_y, rsp_dvel_x, rsp_dvel_y;

   rotation_scoreboard sb;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_ticket = 0;   // bumped by the stimulus to ask for one long stall
   int hold_taken = 0;
   int hold_left = 0;

   particle_frame_rotation_core #(.COORD_WIDTH(COORD_W)) uut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_pos_x(req_beat.pos_x),
      .req_pos_y(req_beat.pos_y),
      .req_pos_z(req_beat.pos_z),
      .req_vel_x(req_beat.vel_x),
      .req_vel_y(req_beat.vel_y),
      .req_vel_z(req_beat.vel_z),
      .req_ref_pos_x(req_beat.ref_pos_x),
      .req_ref_pos_y(req_beat.ref_pos_y),
      .req_ref_pos_z(req_beat.ref_pos_z),
      .req_ref_vel_x(req_beat.ref_vel_x),
      .req_ref_vel_y(req_beat.ref_vel_y),
      .req_ref_vel_z(req_beat.ref_vel_z),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_applied(rsp_applied),
      .rsp_dpos_x(rsp_dpos_x),
      .rsp_dpos_y(rsp_dpos_y),
      .rsp_dvel_x(rsp_dvel_x),
      .rsp_dvel_y(rsp_dvel_y)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // result side: check each accepted beat, then pick next cycle's ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(frame_delta'{rsp_applied, rsp_dpos_x, rsp_dpos_y,
                                      rsp_dvel_x, rsp_dvel_y});
      if (hold_taken != hold_ticket) begin
         hold_taken = hold_ticket;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en)
            quiet = 0;
         else
            quiet++;
      end
      $display("particle_frame_rotation_core regression: fail");
      $finish;
   end

   function automatic particle_beat uniform_particle(logic signed [COORD_W-1:0] part,
                                                     logic signed [COORD_W-1:0] refv);
      particle_beat p;
      p = '{part, part, part, part, part, part, refv, refv, refv, refv, refv, refv};
      return p;
   endfunction

   function automatic logic signed [COORD_W-1:0] small_offset();
      return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
   endfunction

   function automatic logic signed [31:0] random_angle();
      return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
   endfunction

   function automatic logic [LIMIT_W-1:0] random_limit();
      return (64'($urandom_range(0, 2047)) << 32) | 64'($urandom);
   endfunction

   function automatic particle_beat random_particle();
      particle_beat p;
      int mode;
      mode = $urandom_range(0, 9);
      for (int k = 0; k < 12; k++)
         p[k*COORD_W +: COORD_W] = $urandom;
      if (mode < 6) begin
         // particle close to its reference so the radius test can go both ways
         p.pos_x = p.ref_pos_x + small_offset();
         p.pos_y = p.ref_pos_y + small_offset();
         p.pos_z = p.ref_pos_z + small_offset();
         p.vel_x = p.ref_vel_x + small_offset();
         p.vel_y = p.ref_vel_y + small_offset();
      end else if (mode >= 8) begin
         for (int k = 0; k < 12; k++)
            case ($urandom_range(0, 3))
               0: p[k*COORD_W +: COORD_W] = COORD_MAX;
               1: p[k*COORD_W +: COORD_W] = COORD_MIN;
               2: p[k*COORD_W +: COORD_W] = '0;
               default: ;
            endcase
      end
      return p;
   endfunction

   task automatic send_particle(particle_beat p);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < req_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_beat <= p;
      do @(posedge clock); while (!req_ready);
      sb.note_particle(p);
   endtask

   // drop valid and wait until every particle has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic program_regs(logic signed [31:0] cos_v, logic signed [31:0] sin_v,
                               logic signed [31:0] gain_v, logic [LIMIT_W-1:0] limit_v,
                               logic en_v);
      logic [CSR_IDX_W-1:0]  idx [6];
      logic [CSR_DATA_W-1:0] data [6];
      idx = '{CSR_COS_ANGLE, CSR_SIN_ANGLE, CSR_CORIOLIS_GAIN, CSR_RADIUS_LIMIT_SQ,
              CSR_LIMIT_ENABLE, CSR_SPARE_IDX};
      // upper bits of the narrow registers carry junk that must be ignored
      data = '{{32'($urandom), cos_v}, {32'($urandom), sin_v}, {32'($urandom), gain_v},
               limit_v, {32'($urandom), 31'($urandom), en_v},
               {32'($urandom), 32'($urandom)}};
      for (int i = 0; i < 6; i++) begin
         csr_wr_en <= 1'b1;
         csr_addr <= idx[i];
         csr_wdata <= data[i];
         sb.write_reg(idx[i], data[i]);
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   task automatic stream_particles(int count, int hold_at);
      for (int i = 0; i < count; i++) begin
         if (i == hold_at)
            hold_ticket++;
         send_particle(random_particle());
      end
      drain_results();
   endtask

   initial begin
      particle_beat p;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_idle_pct = 29;
      rsp_idle_pct = 80;

      // reset settings: identity rotation, no limit
      send_particle(uniform_particle(32'sd0, 32'sd0));
      send_particle(uniform_particle(COORD_MAX, COORD_MIN));
      send_particle(uniform_particle(COORD_MIN, COORD_MAX));
      drain_results();

      // quarter turn, largest gain: extremes saturate
      program_regs(32'sd0, Q30_ONE, GAIN_MAX, 64'd0, 1'b0);
      send_particle(uniform_particle(COORD_MAX, COORD_MIN));
      send_particle(uniform_particle(COORD_MIN, COORD_MAX));
      p = uniform_particle(32'sd0, 32'sd0);
      p.pos_x = 32'sh0003_0000;
      p.vel_y = 32'sd1;
      send_particle(p);
      p.vel_x = -32'sh0001_8000;
      p.vel_y = 32'sd12345;
      p.ref_pos_y = 32'sd7;
      send_particle(p);
      send_particle(uniform_particle(COORD_MAX, 32'sd0));
      send_particle(uniform_particle(32'sd0, COORD_MIN));
      drain_results();

      // limit enabled at zero: nothing rotates
      program_regs(Q30_NEG_ONE, 32'sd0, GAIN_MIN, 64'd0, 1'b1);
      send_particle(uniform_particle(32'sd0, 32'sd0));
      p = uniform_particle(32'sd0, 32'sd0);
      p.pos_x = 32'sd1;
      send_particle(p);
      drain_results();

      // squared radius one below the limit, then equal to it
      program_regs(COS_45, COS_45, GAIN_MIN, RADIUS_EDGE, 1'b1);
      p = uniform_particle(32'sh0005_0000, 32'sh0005_0000);
      p.pos_x = 32'sh000F_0000;
      p.vel_x = 32'sh0007_0000;
      send_particle(p);
      p.pos_z = 32'sh0005_0001;
      send_particle(p);
      drain_results();

      // full limit: a saturated radius equals it and stays outside
      program_regs(32'sd0, Q30_NEG_ONE, GAIN_MAX, '1, 1'b1);
      send_particle(uniform_particle(COORD_MAX, COORD_MIN));
      p = uniform_particle(32'sd0, 32'sd0);
      p.pos_y = -32'sh0002_0000;
      p.vel_x = 32'sh0100_0000;
      send_particle(p);
      drain_results();

      for (int ph = 0; ph < 6; ph++) begin
         req_idle_pct = (ph < 2) ? 29 : (ph < 4) ? 80 : 0;
         rsp_idle_pct = (ph < 2) ? 80 : (ph < 4) ? 29 : 0;
         case (ph)
            0: program_regs(Q30_NEG_ONE, 32'sd0, $urandom, 64'd0, 1'b0);
            1: program_regs(random_angle(), random_angle(), $urandom, random_limit(), 1'b1);
            2: program_regs(32'sd0, Q30_NEG_ONE, GAIN_MIN, '1, 1'b1);
            3: program_regs($urandom, $urandom, $urandom, {32'($urandom), 32'($urandom)},
                            1'b1);
            4: program_regs(random_angle(), random_angle(), $urandom, random_limit(), 1'b1);
            default: program_regs(random_angle(), random_angle(), $urandom, random_limit(),
                                  1'b0);
         endcase
         stream_particles(PHASE_ITEMS, (ph == 4) ? 20 : -1);
      end

      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("particle_frame_rotation_core regression: pass");
      else
         $display("particle_frame_rotation_core regression: fail");
      $finish;
   end

endmodule
